>>> hdl/cau_pkg.sv
// Shared types, constants and the CORDIC angle table of the complex arithmetic unit.
package cau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MULT  = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_CONJ  = 3'd4,
    CMD_MAG   = 3'd5,
    CMD_PHASE = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDEF = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  // Angle fraction bits, angle table width, angle accumulator width, divider quotient bits.
  localparam int AngFrac = 16;
  localparam int AngW    = 23;
  localparam int ZW      = 26;
  localparam int QW      = 17;

  typedef struct packed {
    logic        ovf;
    logic [15:0] val;
  } sat_t;

  // Per-item side data that rides along with the long arithmetic units.
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] re;
    logic [15:0] im;
    status_e     st;
    logic        dz;
    logic        az;
    logic        arz;
    logic        aiz;
  } side_t;

  function automatic sat_t sat16(input logic signed [33:0] v);
    sat_t r;
    if (v > 34'sd32767) begin
      r.ovf = 1'b1;
      r.val = 16'h7FFF;
    end else if (v < -34'sd32768) begin
      r.ovf = 1'b1;
      r.val = 16'h8000;
    end else begin
      r.ovf = 1'b0;
      r.val = v[15:0];
    end
    return r;
  endfunction

  // atan(2^-i) in degrees with AngFrac fraction bits.
  function automatic logic [AngW-1:0] atan_deg(input int unsigned idx);
    logic [AngW-1:0] a;
    unique case (idx)
      0:  a = 23'd2949120;
      1:  a = 23'd1740967;
      2:  a = 23'd919879;
      3:  a = 23'd466945;
      4:  a = 23'd234379;
      5:  a = 23'd117304;
      6:  a = 23'd58666;
      7:  a = 23'd29335;
      8:  a = 23'd14668;
      9:  a = 23'd7334;
      10: a = 23'd3667;
      11: a = 23'd1833;
      12: a = 23'd917;
      13: a = 23'd458;
      14: a = 23'd229;
      15: a = 23'd115;
      16: a = 23'd57;
      17: a = 23'd29;
      18: a = 23'd14;
      19: a = 23'd7;
      20: a = 23'd4;
      21: a = 23'd2;
      22: a = 23'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> hdl/cau_div.sv
// Pipelined restoring divider: one quotient bit per stage, rounded numerator prepared up front.
module cau_div #(
  parameter int FRAC_BITS = 8,
  parameter int DEPTH     = 18
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [32:0]    num_i,
  input  logic [31:0]           den_i,
  output logic [cau_pkg::QW-1:0] quo_o,
  output logic                  ovf_o,
  output logic                  neg_o
);
  import cau_pkg::*;

  localparam int NW = 33 + FRAC_BITS;
  localparam int HW = NW - QW;

  logic [32:0]   mag;
  logic [NW-1:0] nfull;
  logic [HW-1:0] hi;
  logic          ovf0;

  logic [31:0]   rem_q [DEPTH];
  logic [QW-1:0] quo_q [DEPTH];
  logic [QW-1:0] lo_q  [DEPTH];
  logic          ovf_q [DEPTH];
  logic          neg_q [DEPTH];
  logic [31:0]   den_q [DEPTH];

  // Add half the divisor so the truncating quotient rounds to nearest.
  always_comb begin
    mag   = num_i[32] ? 33'(-num_i) : 33'(num_i);
    nfull = (NW'(mag) << FRAC_BITS) + NW'(den_i >> 1);
    hi    = nfull[NW-1:QW];
    ovf0  = 33'(hi) >= 33'(den_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= 32'(hi);
      quo_q[0] <= '0;
      lo_q[0]  <= nfull[QW-1:0];
      ovf_q[0] <= ovf0;
      neg_q[0] <= num_i[32];
      den_q[0] <= den_i;
    end
  end

  for (genvar s = 1; s < DEPTH; s++) begin : g_stage
    if (s <= QW) begin : g_step
      logic [32:0] t;
      logic        ge;
      assign t  = {rem_q[s-1], lo_q[s-1][QW-1]};
      assign ge = t >= {1'b0, den_q[s-1]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? 32'(t - {1'b0, den_q[s-1]}) : 32'(t);
          quo_q[s] <= {quo_q[s-1][QW-2:0], ge};
          lo_q[s]  <= {lo_q[s-1][QW-2:0], 1'b0};
          ovf_q[s] <= ovf_q[s-1];
          neg_q[s] <= neg_q[s-1];
          den_q[s] <= den_q[s-1];
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_q[s-1];
          quo_q[s] <= quo_q[s-1];
          lo_q[s]  <= lo_q[s-1];
          ovf_q[s] <= ovf_q[s-1];
          neg_q[s] <= neg_q[s-1];
          den_q[s] <= den_q[s-1];
        end
      end
    end
  end

  assign quo_o = quo_q[DEPTH-1];
  assign ovf_o = ovf_q[DEPTH-1];
  assign neg_o = neg_q[DEPTH-1];

endmodule

>>> hdl/cau_sqrt.sv
// Pipelined digit-by-digit integer square root, two radicand bits per stage.
module cau_sqrt #(
  parameter int DEPTH = 18
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] rad_i,
  output logic [15:0] root_o,
  output logic [16:0] rem_o
);
  localparam int Steps = 16;

  logic [31:0] x_q [DEPTH];
  logic [31:0] r_q [DEPTH];

  for (genvar s = 0; s < DEPTH; s++) begin : g_stage
    logic [31:0] xp, rp;
    if (s == 0) begin : g_first
      assign xp = rad_i;
      assign rp = '0;
    end else begin : g_next
      assign xp = x_q[s-1];
      assign rp = r_q[s-1];
    end
    if (s < Steps) begin : g_step
      localparam logic [31:0] Bit = 32'd1 << (2 * (Steps - 1 - s));
      logic [32:0] sum;
      logic        ge;
      assign sum = 33'(rp) + 33'(Bit);
      assign ge  = 33'(xp) >= sum;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[s] <= ge ? xp - 32'(sum) : xp;
          r_q[s] <= ge ? (rp >> 1) + Bit : rp >> 1;
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[s] <= xp;
          r_q[s] <= rp;
        end
      end
    end
  end

  assign root_o = r_q[DEPTH-1][15:0];
  assign rem_o  = x_q[DEPTH-1][16:0];

endmodule

>>> hdl/cau_cordic.sv
// Pipelined vectoring CORDIC that accumulates the angle of (x, y) in degrees.
module cau_cordic #(
  parameter int STEPS = 16,
  parameter int DEPTH = 18
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [15:0]                  xa_i,
  input  logic [15:0]                  ya_i,
  output logic signed [cau_pkg::ZW-1:0] ang_o
);
  import cau_pkg::*;

  localparam int XW = 36;

  logic signed [XW-1:0] x_q [DEPTH];
  logic signed [XW-1:0] y_q [DEPTH];
  logic signed [ZW-1:0] z_q [DEPTH];

  for (genvar s = 0; s < DEPTH; s++) begin : g_stage
    logic signed [XW-1:0] xp, yp;
    logic signed [ZW-1:0] zp;
    if (s == 0) begin : g_first
      assign xp = $signed(XW'({xa_i, {AngFrac{1'b0}}}));
      assign yp = $signed(XW'({ya_i, {AngFrac{1'b0}}}));
      assign zp = '0;
    end else begin : g_next
      assign xp = x_q[s-1];
      assign yp = y_q[s-1];
      assign zp = z_q[s-1];
    end
    if (s < STEPS) begin : g_step
      localparam logic signed [ZW-1:0] Ang = $signed(ZW'(atan_deg(s)));
      logic signed [XW-1:0] xs, ys;
      logic                 pos;
      assign xs  = xp >>> s;
      assign ys  = yp >>> s;
      assign pos = !yp[XW-1] && (yp != '0);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[s] <= pos ? xp + ys : xp - ys;
          y_q[s] <= pos ? yp - xs : yp + xs;
          z_q[s] <= pos ? zp + Ang : zp - Ang;
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[s] <= xp;
          y_q[s] <= yp;
          z_q[s] <= zp;
        end
      end
    end
  end

  assign ang_o = z_q[DEPTH-1];

endmodule

>>> hdl/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: operand products, unit pipelines and result formatting.
// Fully pipelined complex ALU on signed fixed-point operands: one item may be transferred
// in every cycle, and each result passes stage A, stage B, the unit pipelines and the
// output register. The unit depth is set by the longest unit, either the 18-stage divider
// (one rounding stage plus 17 quotient bits) or the CORDIC with one stage per step; the
// square root takes 16 stages and is padded to the same length. When the output is not
// taken the whole pipeline holds, so in_ready_o drops only while a result is stalled.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS    = 8,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [15:0] a_real_i,
  input  logic signed [15:0] a_imag_i,
  input  logic signed [15:0] b_real_i,
  input  logic signed [15:0] b_imag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] out_real_o,
  output logic signed [15:0] out_imag_o,
  output logic [15:0]        out_scalar_o,
  output logic [1:0]         status_o
);
  import cau_pkg::*;

  localparam int Depth = (CORDIC_STEPS > QW + 1) ? CORDIC_STEPS : QW + 1;

  logic adv;

  // Stage A: operands and products.
  logic               vld_a_q;
  logic [2:0]         cmd_a_q;
  logic signed [15:0] ar_a_q, ai_a_q, br_a_q, bi_a_q;
  logic signed [31:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q;
  logic signed [31:0] sq_ar_q, sq_ai_q, sq_br_q, sq_bi_q;

  // Stage B: sums, short results and unit operands.
  logic               vld_b_q;
  side_t              side_d, side_b_q;
  logic signed [32:0] num_re_d, num_im_d, num_re_q, num_im_q;
  logic [31:0]        den_d, den_q, rad_d, rad_q;
  logic [15:0]        xa_d, ya_d, xa_q, ya_q;

  logic signed [16:0] add_re, add_im, sub_re, sub_im, neg_ai;
  logic signed [32:0] mre_sum, mim_sum;
  logic signed [33:0] mre_rnd, mim_rnd;
  sat_t               s_re, s_im;

  // Side data aligned with the units.
  logic               vld_dl_q [Depth];
  side_t              side_dl_q [Depth];

  // Unit results.
  logic [QW-1:0]        dre_quo, dim_quo;
  logic                 dre_ovf, dim_ovf, dre_neg, dim_neg;
  logic [15:0]          sq_root;
  logic [16:0]          sq_rem;
  logic signed [ZW-1:0] ang;

  // Output stage.
  side_t        side_o;
  sat_t         dre_s, dim_s;
  logic [16:0]  root_rnd;
  logic [AngW-1:0] z_clamp;
  logic [23:0]  phase_w, sc_w;
  logic [15:0]  re_d, im_d, sc_d;
  status_e      st_d;
  logic         out_valid_q;
  logic [15:0]  out_re_q, out_im_q, out_sc_q;
  status_e      out_st_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd_a_q <= cmd_i;
      ar_a_q  <= a_real_i;
      ai_a_q  <= a_imag_i;
      br_a_q  <= b_real_i;
      bi_a_q  <= b_imag_i;
      p_rr_q  <= a_real_i * b_real_i;
      p_ii_q  <= a_imag_i * b_imag_i;
      p_ir_q  <= a_imag_i * b_real_i;
      p_ri_q  <= a_real_i * b_imag_i;
      sq_ar_q <= a_real_i * a_real_i;
      sq_ai_q <= a_imag_i * a_imag_i;
      sq_br_q <= b_real_i * b_real_i;
      sq_bi_q <= b_imag_i * b_imag_i;
    end
  end

  always_comb begin
    add_re  = 17'(ar_a_q) + 17'(br_a_q);
    add_im  = 17'(ai_a_q) + 17'(bi_a_q);
    sub_re  = 17'(ar_a_q) - 17'(br_a_q);
    sub_im  = 17'(ai_a_q) - 17'(bi_a_q);
    neg_ai  = -17'(ai_a_q);
    mre_sum = 33'(p_rr_q) - 33'(p_ii_q);
    mim_sum = 33'(p_ir_q) + 33'(p_ri_q);
    // Round half up before dropping the fraction.
    mre_rnd = (34'(mre_sum) + (34'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    mim_rnd = (34'(mim_sum) + (34'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    side_d.cmd = cmd_e'(cmd_a_q);
    side_d.re  = '0;
    side_d.im  = '0;
    side_d.st  = ST_OK;
    side_d.dz  = (br_a_q == '0) && (bi_a_q == '0);
    side_d.az  = (ar_a_q == '0) && (ai_a_q == '0);
    side_d.arz = ar_a_q == '0;
    side_d.aiz = ai_a_q == '0;
    s_re = '0;
    s_im = '0;
    unique case (cmd_e'(cmd_a_q))
      CMD_ADD: begin
        s_re = sat16(34'(add_re));
        s_im = sat16(34'(add_im));
      end
      CMD_SUB: begin
        s_re = sat16(34'(sub_re));
        s_im = sat16(34'(sub_im));
      end
      CMD_MULT: begin
        s_re = sat16(mre_rnd);
        s_im = sat16(mim_rnd);
      end
      CMD_CONJ: begin
        s_re = sat16(34'(ar_a_q));
        s_im = sat16(34'(neg_ai));
      end
      CMD_DIV, CMD_MAG, CMD_PHASE: ;
      default: side_d.st = ST_UNDEF;
    endcase
    side_d.re = s_re.val;
    side_d.im = s_im.val;
    if (s_re.ovf || s_im.ovf) side_d.st = ST_SAT;

    num_re_d = 33'(p_rr_q) + 33'(p_ii_q);
    num_im_d = 33'(p_ir_q) - 33'(p_ri_q);
    den_d    = $unsigned(sq_br_q) + $unsigned(sq_bi_q);
    rad_d    = $unsigned(sq_ar_q) + $unsigned(sq_ai_q);
    xa_d     = ar_a_q[15] ? 16'(~ar_a_q + 16'd1) : ar_a_q;
    ya_d     = ai_a_q[15] ? 16'(~ai_a_q + 16'd1) : ai_a_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_b_q <= side_d;
      num_re_q <= num_re_d;
      num_im_q <= num_im_d;
      den_q    <= den_d;
      rad_q    <= rad_d;
      xa_q     <= xa_d;
      ya_q     <= ya_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_dl_q[0] <= side_b_q;
      for (int k = 1; k < Depth; k++) side_dl_q[k] <= side_dl_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q     <= 1'b0;
      vld_b_q     <= 1'b0;
      for (int k = 0; k < Depth; k++) vld_dl_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_a_q     <= in_valid_i;
      vld_b_q     <= vld_a_q;
      vld_dl_q[0] <= vld_b_q;
      for (int k = 1; k < Depth; k++) vld_dl_q[k] <= vld_dl_q[k-1];
      out_valid_q <= vld_dl_q[Depth-1];
    end
  end

  cau_div #(.FRAC_BITS(FRAC_BITS), .DEPTH(Depth)) u_div_re (
    .clk_i, .en_i(adv), .num_i(num_re_q), .den_i(den_q),
    .quo_o(dre_quo), .ovf_o(dre_ovf), .neg_o(dre_neg)
  );

  cau_div #(.FRAC_BITS(FRAC_BITS), .DEPTH(Depth)) u_div_im (
    .clk_i, .en_i(adv), .num_i(num_im_q), .den_i(den_q),
    .quo_o(dim_quo), .ovf_o(dim_ovf), .neg_o(dim_neg)
  );

  cau_sqrt #(.DEPTH(Depth)) u_sqrt (
    .clk_i, .en_i(adv), .rad_i(rad_q), .root_o(sq_root), .rem_o(sq_rem)
  );

  cau_cordic #(.STEPS(CORDIC_STEPS), .DEPTH(Depth)) u_cordic (
    .clk_i, .en_i(adv), .xa_i(xa_q), .ya_i(ya_q), .ang_o(ang)
  );

  function automatic sat_t quo_sat(input logic [QW-1:0] q, input logic ovf,
                                   input logic neg);
    sat_t r;
    if (ovf) begin
      r.ovf = 1'b1;
      r.val = neg ? 16'h8000 : 16'h7FFF;
    end else if (!neg) begin
      r.ovf = q > 17'd32767;
      r.val = r.ovf ? 16'h7FFF : q[15:0];
    end else begin
      r.ovf = q > 17'd32768;
      r.val = r.ovf ? 16'h8000 : 16'(~q + 17'd1);
    end
    return r;
  endfunction

  always_comb begin
    side_o   = side_dl_q[Depth-1];
    dre_s    = quo_sat(dre_quo, dre_ovf, dre_neg);
    dim_s    = quo_sat(dim_quo, dim_ovf, dim_neg);
    root_rnd = 17'(sq_root) + 17'(sq_rem > 17'(sq_root));
    // Clamp the angle to 0..90 degrees, then round half up to the output fraction.
    if (ang[ZW-1]) begin
      z_clamp = '0;
    end else if (ang > $signed(ZW'(90 << AngFrac))) begin
      z_clamp = AngW'(90 << AngFrac);
    end else begin
      z_clamp = ang[AngW-1:0];
    end
    phase_w = (24'(z_clamp) + (24'd1 << (AngFrac - FRAC_BITS - 1))) >> (AngFrac - FRAC_BITS);

    re_d = side_o.re;
    im_d = side_o.im;
    st_d = side_o.st;
    sc_w = '0;
    unique case (side_o.cmd)
      CMD_DIV: begin
        if (side_o.dz) begin
          st_d = ST_UNDEF;
        end else begin
          re_d = dre_s.val;
          im_d = dim_s.val;
          if (dre_s.ovf || dim_s.ovf) st_d = ST_SAT;
        end
      end
      CMD_MAG: sc_w = 24'(root_rnd);
      CMD_PHASE: begin
        priority if (side_o.az) st_d = ST_UNDEF;
        else if (side_o.arz) sc_w = 24'd90 << FRAC_BITS;
        else if (side_o.aiz) sc_w = '0;
        else sc_w = phase_w;
      end
      default: ;
    endcase
    if (sc_w > 24'd65535) begin
      sc_d = 16'hFFFF;
      st_d = ST_SAT;
    end else begin
      sc_d = sc_w[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_re_q <= re_d;
      out_im_q <= im_d;
      out_sc_q <= sc_d;
      out_st_q <= st_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_real_o   = out_re_q;
  assign out_imag_o   = out_im_q;
  assign out_scalar_o = out_sc_q;
  assign status_o     = out_st_q;

endmodule

>>> hdl/cau_checker.sv
// Port-level checks of the complex arithmetic unit, bound to the top level.
module cau_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] out_real_o,
  input logic signed [15:0] out_imag_o,
  input logic [15:0]        out_scalar_o,
  input logic [1:0]         status_o
);
  import cau_pkg::*;

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_real_o) &&
    $stable(out_imag_o) && $stable(out_scalar_o) && $stable(status_o))
    else $error("stalled result changed");

  // The input side stalls only behind a stalled output.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_UNDEF || status_o == ST_SAT)
    else $error("unknown status code");

  // Undefined results are all zero.
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_UNDEF |->
    out_real_o == '0 && out_imag_o == '0 && out_scalar_o == '0)
    else $error("undefined result not zero");

  // A scalar result leaves the complex fields at zero.
  a_scalar_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_scalar_o != '0 |-> out_real_o == '0 && out_imag_o == '0)
    else $error("scalar and complex results mixed");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
